// ----- hdl/iptlm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iptlm_pkg
// shared widths, operation codes and status codes of the page table line manager
// ----------------------------------------------------------------------------
package iptlm_pkg;

  localparam int OP_W       = 2;
  localparam int OWNER_W    = 8;
  localparam int FRAME_W    = 5;
  localparam int OFFSET_W   = 11;
  localparam int PAGE_W     = 14;
  localparam int STATUS_W   = 3;
  localparam int ADDR_W     = 11;
  localparam int FREE_W     = 12;
  localparam int CFG_LPP_W  = 7;
  localparam int PADDR_W    = 3;

  localparam int DEF_FRAMES  = 32;
  localparam int DEF_MAX_LPP = 64;

  localparam logic [CFG_LPP_W-1:0] LPP_RESET = 7'd16;
  localparam logic [PAGE_W-1:0]    PAGE_LIMIT = 14'd10000;
  localparam logic [PAGE_W-1:0]    PAGE_MAX   = 14'd9999;

  // register index
  localparam logic REG_LPP = 1'b0;

  // operations
  localparam logic [OP_W-1:0] OP_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_XLATE  = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

endpackage
`default_nettype wire

// ----- hdl/iptlm_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iptlm_table
// frame table memory with per-frame used flags, one read and one write a cycle
// ----------------------------------------------------------------------------
module iptlm_table #(
  parameter int FRAMES = 32,
  parameter int CNT_W  = 7
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           rd_en,
  input  wire  [$clog2(FRAMES)-1:0]     rd_addr,
  output logic                          rd_used,
  output logic [iptlm_pkg::OWNER_W-1:0] rd_owner,
  output logic [iptlm_pkg::PAGE_W-1:0]  rd_page,
  output logic [CNT_W-1:0]              rd_count,
  input  wire                           wr_en,
  input  wire  [$clog2(FRAMES)-1:0]     wr_addr,
  input  wire                           wr_used,
  input  wire  [iptlm_pkg::OWNER_W-1:0] wr_owner,
  input  wire  [iptlm_pkg::PAGE_W-1:0]  wr_page,
  input  wire  [CNT_W-1:0]              wr_count
);
  import iptlm_pkg::*;

  localparam int EW = OWNER_W + PAGE_W + CNT_W;

  logic [EW-1:0]     mem [FRAMES];
  logic [FRAMES-1:0] used;
  logic [EW-1:0]     q;
  logic              q_used;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_owner, wr_page, wr_count};
    end
    if (rd_en) begin
      q      <= mem[rd_addr];
      q_used <= used[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr_en) begin
      used[wr_addr] <= wr_used;
    end
  end

  // a free frame reads as all zero
  assign rd_used  = q_used;
  assign rd_owner = q_used ? q[EW-1 -: OWNER_W] : '0;
  assign rd_page  = q_used ? q[CNT_W +: PAGE_W] : '0;
  assign rd_count = q_used ? q[CNT_W-1:0] : '0;

endmodule
`default_nettype wire

// ----- hdl/inverted_page_table_line_manager.sv -----
`default_nettype none
// table sweeps: op 1 makes one, op 0 and op 3 make two, op 3 adding a compaction pass
//   over its M moved frames after the first; op 2 makes one per page hop plus the free
//   line sweep, all through the single table read port
// operation: one transaction at a time, the next one taken once the result has been loaded
//   into the output register; a finished result sits there while the next one is processed
// reset: synchronous, every frame free, lines_per_page back to 16, no clearing pass
// ----------------------------------------------------------------------------
// inverted_page_table_line_manager
// inverted page table with per-frame owner, page and line count; places,
// appends and translates lines, removes pages, and reports free lines after each one
// ----------------------------------------------------------------------------
module inverted_page_table_line_manager #(
  parameter int FRAMES             = iptlm_pkg::DEF_FRAMES,
  parameter int MAX_LINES_PER_PAGE = iptlm_pkg::DEF_MAX_LPP
) (
  input  wire                            clk,
  input  wire                            rst,
  // input channel
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [iptlm_pkg::OP_W-1:0]     op,
  input  wire  [iptlm_pkg::OWNER_W-1:0]  pid,
  input  wire  [iptlm_pkg::FRAME_W-1:0]  frame,
  input  wire  [iptlm_pkg::OFFSET_W-1:0] line_offset,
  input  wire  [iptlm_pkg::PAGE_W-1:0]   page,
  // output channel
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [iptlm_pkg::STATUS_W-1:0] status,
  output logic [iptlm_pkg::FRAME_W-1:0]  result_frame,
  output logic [iptlm_pkg::ADDR_W-1:0]   line_address,
  output logic [iptlm_pkg::FRAME_W-1:0]  moved_frames,
  output logic [iptlm_pkg::FREE_W-1:0]   free_lines,
  // configuration port
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [iptlm_pkg::PADDR_W-1:0]  paddr,
  input  wire  [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import iptlm_pkg::*;

  localparam int IW   = $clog2(FRAMES);
  localparam int CW   = $clog2(MAX_LINES_PER_PAGE + 1);
  localparam int MW   = IW + CW + 1;
  localparam int SUMW = $clog2(FRAMES * MAX_LINES_PER_PAGE + 1);

  localparam logic [IW-1:0] LAST_FRAME = IW'(FRAMES - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN0 = 4'd1;
  localparam logic [3:0] S_DEC0  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CHK1  = 4'd4;
  localparam logic [3:0] S_CHK2  = 4'd5;
  localparam logic [3:0] S_HOP   = 4'd6;
  localparam logic [3:0] S_HOPD  = 4'd7;
  localparam logic [3:0] S_FIN2  = 4'd8;
  localparam logic [3:0] S_FIND3 = 4'd9;
  localparam logic [3:0] S_REM3  = 4'd10;
  localparam logic [3:0] S_SHIFT = 4'd11;
  localparam logic [3:0] S_CLR   = 4'd12;
  localparam logic [3:0] S_FREE  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state;

  // configuration
  logic [CFG_LPP_W-1:0] cfg_lpp;
  logic [CW-1:0]        lpp;
  logic                 cfg_wr;

  // captured transaction
  logic [OP_W-1:0]     op_q;
  logic [OWNER_W-1:0]  pid_q;
  logic [FRAME_W-1:0]  frame_q;
  logic [OFFSET_W-1:0] off_q;
  logic [PAGE_W-1:0]   page_q;
  logic                frame_ok;
  logic [IW-1:0]       frame_idx;

  // sweep control
  logic [IW:0]   sc_cnt;
  logic          rvalid;
  logic [IW-1:0] ridx;
  logic          scan_issue;
  logic          scan_last;

  // table ports
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               rd_used;
  logic [OWNER_W-1:0] rd_owner;
  logic [PAGE_W-1:0]  rd_page;
  logic [CW-1:0]      rd_count;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic               wr_used;
  logic [OWNER_W-1:0] wr_owner;
  logic [PAGE_W-1:0]  wr_page;
  logic [CW-1:0]      wr_count;

  // first-line search
  logic              has_max;
  logic [PAGE_W-1:0] maxp;
  logic [IW-1:0]     hfrm;
  logic [CW-1:0]     hcnt;
  logic              has_free;
  logic [IW-1:0]     nfrm;
  logic              reuse;
  logic              alloc;
  logic [PAGE_W-1:0] new_page;

  // translation walk
  logic [OWNER_W-1:0]  own;
  logic [PAGE_W-1:0]   cur;
  logic [IW-1:0]       tgt;
  logic [CW-1:0]       tcnt;
  logic [OFFSET_W-1:0] rem;
  logic [OFFSET_W-1:0] rem_next;
  logic                found;
  logic [PAGE_W-1:0]   best;
  logic [IW-1:0]       bfrm;
  logic [CW-1:0]       bcnt;

  // removal
  logic          fnd;
  logic [IW-1:0] ffrm;
  logic [IW-1:0] mcnt;
  logic [IW-1:0] fm;

  // free line sum
  logic [SUMW-1:0] sum;

  // result being built
  logic [STATUS_W-1:0] res_status;
  logic [IW-1:0]       res_frame;
  logic [MW-1:0]       res_addr;
  logic [IW-1:0]       res_moved;

  // effective lines per page, clamped to 1..MAX_LINES_PER_PAGE
  always_comb begin
    if (cfg_lpp == '0) begin
      lpp = CW'(1);
    end else if (32'(cfg_lpp) > MAX_LINES_PER_PAGE) begin
      lpp = CW'(MAX_LINES_PER_PAGE);
    end else begin
      lpp = CW'(cfg_lpp);
    end
  end

  // configuration port: only lines_per_page is present
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LPP);
  assign prdata = (paddr[2] == REG_LPP) ? 32'(cfg_lpp) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_lpp <= LPP_RESET;
    end else if (cfg_wr) begin
      cfg_lpp <= pwdata[CFG_LPP_W-1:0];
    end
  end

  assign frame_ok   = 32'(frame_q) < FRAMES;
  assign frame_idx  = IW'(frame_q);
  assign scan_issue = sc_cnt < (IW + 1)'(FRAMES);
  assign scan_last  = rvalid && (ridx == LAST_FRAME);

  assign reuse    = has_max && (hcnt == '0);
  assign alloc    = has_free && (!has_max || (maxp < PAGE_MAX));
  assign new_page = has_max ? maxp + PAGE_W'(1) : '0;
  assign rem_next = rem - OFFSET_W'(lpp);

  assign in_stall = (state != S_IDLE);

  // table access: reads stream through the sweeps, writes land at decisions and stream through compaction
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = sc_cnt[IW-1:0];
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_used  = 1'b0;
    wr_owner = '0;
    wr_page  = '0;
    wr_count = '0;
    unique case (state)
      S_SCAN0, S_HOP, S_FIND3, S_FREE: begin
        rd_en = scan_issue;
      end
      S_RD: begin
        rd_en   = frame_ok;
        rd_addr = frame_idx;
      end
      S_DEC0: begin
        if (reuse) begin
          wr_en    = 1'b1;
          wr_addr  = hfrm;
          wr_used  = 1'b1;
          wr_owner = pid_q;
          wr_page  = maxp;
          wr_count = CW'(1);
        end else if (alloc) begin
          wr_en    = 1'b1;
          wr_addr  = nfrm;
          wr_used  = 1'b1;
          wr_owner = pid_q;
          wr_page  = new_page;
          wr_count = CW'(1);
        end
      end
      S_CHK1: begin
        if (rd_used && (rd_count < lpp)) begin
          wr_en    = 1'b1;
          wr_addr  = frame_idx;
          wr_used  = 1'b1;
          wr_owner = rd_owner;
          wr_page  = rd_page;
          wr_count = rd_count + CW'(1);
        end
      end
      S_REM3: begin
        // nothing above: just free the page
        if (fnd && (mcnt == '0)) begin
          wr_en   = 1'b1;
          wr_addr = ffrm;
        end
      end
      S_SHIFT: begin
        rd_en = sc_cnt <= {1'b0, fm};
        if (rvalid) begin
          wr_en    = 1'b1;
          wr_addr  = ridx - IW'(1);
          wr_used  = rd_used;
          wr_owner = rd_owner;
          wr_page  = rd_page;
          wr_count = rd_count;
        end
      end
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = fm;
      end
      default: begin
      end
    endcase
  end

  iptlm_table #(
    .FRAMES (FRAMES),
    .CNT_W  (CW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_used  (rd_used),
    .rd_owner (rd_owner),
    .rd_page  (rd_page),
    .rd_count (rd_count),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_used  (wr_used),
    .wr_owner (wr_owner),
    .wr_page  (wr_page),
    .wr_count (wr_count)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rvalid <= rd_en;
      if (rd_en) begin
        sc_cnt <= sc_cnt + (IW + 1)'(1);
      end
      // a result leaving in the cycle a new one is loaded keeps valid high
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= op;
            pid_q      <= pid;
            frame_q    <= frame;
            off_q      <= line_offset;
            page_q     <= page;
            res_status <= ST_OK;
            res_frame  <= '0;
            res_addr   <= '0;
            res_moved  <= '0;
            sc_cnt     <= '0;
            has_max    <= 1'b0;
            has_free   <= 1'b0;
            fnd        <= 1'b0;
            mcnt       <= '0;
            unique case (op)
              OP_FIRST:            state <= S_SCAN0;
              OP_APPEND, OP_XLATE: state <= S_RD;
              OP_REMOVE:           state <= S_FIND3;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_SCAN0: begin
          if (rvalid) begin
            // strictly greater keeps the lowest frame of the highest page
            if (rd_used && (rd_owner == pid_q) && (!has_max || (rd_page > maxp))) begin
              has_max <= 1'b1;
              maxp    <= rd_page;
              hfrm    <= ridx;
              hcnt    <= rd_count;
            end
            if (!rd_used && !has_free) begin
              has_free <= 1'b1;
              nfrm     <= ridx;
            end
          end
          if (scan_last) begin
            state <= S_DEC0;
          end
        end
        S_DEC0: begin
          if (reuse) begin
            res_frame <= hfrm;
            res_addr  <= MW'(hfrm) * MW'(lpp);
          end else if (alloc) begin
            res_frame <= nfrm;
            res_addr  <= MW'(nfrm) * MW'(lpp);
          end else begin
            res_status <= ST_NO_FREE;
          end
          sc_cnt <= '0;
          sum    <= '0;
          state  <= S_FREE;
        end
        S_RD: begin
          if (!frame_ok) begin
            res_status <= (op_q == OP_APPEND) ? ST_NOTFOUND : ST_INVALID;
            sc_cnt     <= '0;
            sum        <= '0;
            state      <= S_FREE;
          end else begin
            state <= (op_q == OP_APPEND) ? S_CHK1 : S_CHK2;
          end
        end
        S_CHK1: begin
          if (!rd_used) begin
            res_status <= ST_NOTFOUND;
          end else if (rd_count >= lpp) begin
            res_status <= ST_FULL;
          end else begin
            res_frame <= frame_idx;
            res_addr  <= MW'(frame_idx) * MW'(lpp) + MW'(rd_count);
          end
          sc_cnt <= '0;
          sum    <= '0;
          state  <= S_FREE;
        end
        S_CHK2: begin
          if (!rd_used) begin
            res_status <= ST_INVALID;
            sc_cnt     <= '0;
            sum        <= '0;
            state      <= S_FREE;
          end else begin
            own  <= rd_owner;
            cur  <= rd_page;
            tgt  <= frame_idx;
            tcnt <= rd_count;
            rem  <= off_q;
            if (off_q >= OFFSET_W'(lpp)) begin
              sc_cnt <= '0;
              found  <= 1'b0;
              state  <= S_HOP;
            end else begin
              state <= S_FIN2;
            end
          end
        end
        S_HOP: begin
          // next page of the owner above the current one
          if (rvalid && rd_used && (rd_owner == own) && (rd_page > cur) &&
              (rd_page <= PAGE_LIMIT) && (!found || (rd_page < best))) begin
            found <= 1'b1;
            best  <= rd_page;
            bfrm  <= ridx;
            bcnt  <= rd_count;
          end
          if (scan_last) begin
            state <= S_HOPD;
          end
        end
        S_HOPD: begin
          if (!found) begin
            res_status <= ST_INVALID;
            sc_cnt     <= '0;
            sum        <= '0;
            state      <= S_FREE;
          end else begin
            cur  <= best;
            tgt  <= bfrm;
            tcnt <= bcnt;
            rem  <= rem_next;
            if (rem_next >= OFFSET_W'(lpp)) begin
              sc_cnt <= '0;
              found  <= 1'b0;
              state  <= S_HOP;
            end else begin
              state <= S_FIN2;
            end
          end
        end
        S_FIN2: begin
          if (rem >= OFFSET_W'(tcnt)) begin
            res_status <= ST_INVALID;
          end else begin
            res_frame <= tgt;
            res_addr  <= MW'(tgt) * MW'(lpp) + MW'(rem);
          end
          sc_cnt <= '0;
          sum    <= '0;
          state  <= S_FREE;
        end
        S_FIND3: begin
          if (rvalid) begin
            if (!fnd) begin
              if (rd_used && (rd_owner == pid_q) && (rd_page == page_q)) begin
                fnd  <= 1'b1;
                ffrm <= ridx;
              end
            end else if (rd_used) begin
              mcnt <= mcnt + IW'(1);
            end
          end
          if (scan_last) begin
            state <= S_REM3;
          end
        end
        S_REM3: begin
          if (!fnd) begin
            res_status <= ST_NOTFOUND;
            sc_cnt     <= '0;
            sum        <= '0;
            state      <= S_FREE;
          end else begin
            res_frame <= ffrm;
            res_moved <= mcnt;
            fm        <= ffrm + mcnt;
            if (mcnt == '0) begin
              sc_cnt <= '0;
              sum    <= '0;
              state  <= S_FREE;
            end else begin
              // compaction reads one ahead of the write
              sc_cnt <= {1'b0, ffrm} + (IW + 1)'(1);
              state  <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (rvalid && (ridx == fm)) begin
            state <= S_CLR;
          end
        end
        S_CLR: begin
          sc_cnt <= '0;
          sum    <= '0;
          state  <= S_FREE;
        end
        S_FREE: begin
          if (rvalid && (rd_count < lpp)) begin
            sum <= sum + SUMW'(lpp - rd_count);
          end
          if (scan_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register, loaded when the result moves out of the sequencer
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      status       <= res_status;
      result_frame <= FRAME_W'(res_frame);
      line_address <= ADDR_W'(res_addr);
      moved_frames <= FRAME_W'(res_moved);
      free_lines   <= FREE_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    ridx <= rd_addr;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("sequencer idle right after a transaction was taken");

  a_shift_has_moves: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> res_moved != '0)
    else $error("compaction running with no frames to move");

  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("read and write of the same table entry in one cycle");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_NOTFOUND)
    else $error("status code out of range");
`endif

endmodule
`default_nettype wire

// ----- bench/inverted_page_table_line_manager_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inverted_page_table_line_manager_tb
// drives place, append, translate and remove transactions under random
// sender gaps and receiver stalls, predicts each result from a shadow copy of
// the frame table, and checks every result field in order
// ----------------------------------------------------------------------------
module inverted_page_table_line_manager_tb;
  import iptlm_pkg::*;

  localparam int NFRAMES   = DEF_FRAMES;
  localparam int MAXLPP    = DEF_MAX_LPP;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [OWNER_W-1:0]  pid;
    logic [FRAME_W-1:0]  frame;
    logic [OFFSET_W-1:0] offset;
    logic [PAGE_W-1:0]   page;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  rframe;
    logic [ADDR_W-1:0]   addr;
    logic [FRAME_W-1:0]  moved;
    logic [FREE_W-1:0]   free;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0]     op = '0;
  logic [OWNER_W-1:0]  pid = '0;
  logic [FRAME_W-1:0]  frame = '0;
  logic [OFFSET_W-1:0] line_offset = '0;
  logic [PAGE_W-1:0]   page = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [FRAME_W-1:0]  result_frame;
  logic [ADDR_W-1:0]   line_address;
  logic [FRAME_W-1:0]  moved_frames;
  logic [FREE_W-1:0]   free_lines;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  inverted_page_table_line_manager DUT (
    .clk, .rst, .in_valid, .in_stall, .op, .pid, .frame, .line_offset, .page,
    .out_valid, .out_stall, .status, .result_frame, .line_address, .moved_frames,
    .free_lines, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow frame table and register
  bit       tbl_used [NFRAMES];
  int       tbl_owner[NFRAMES];
  int       tbl_page [NFRAMES];
  int       tbl_count[NFRAMES];
  int       lpp_reg = LPP_RESET;

  cmd_t   cmd_q[$];
  reply_t reply_q[$];
  bit     failed = 1'b0;
  int     idle_cycles = 0;

  function automatic int lookup_frame(int who, int pg);
    for (int i = 0; i < NFRAMES; i++)
      if (tbl_used[i] && tbl_owner[i] == who && tbl_page[i] == pg) return i;
    return -1;
  endfunction

  // advance the shadow table by one transaction and return its reply
  task automatic table_update(input cmd_t c, output reply_t r);
    int l, maxp, f, h, tgt, line, hops, who, cur, best, p, mv;
    l = lpp_reg;
    if (l < 1) l = 1;
    if (l > MAXLPP) l = MAXLPP;
    r = '0;
    case (c.op)
      OP_FIRST: begin
        maxp = -1;
        f = -1;
        for (int i = 0; i < NFRAMES; i++)
          if (tbl_used[i] && tbl_owner[i] == c.pid && tbl_page[i] > maxp) maxp = tbl_page[i];
        if (maxp >= 0) begin
          h = lookup_frame(c.pid, maxp);
          if (h >= 0 && tbl_count[h] == 0) f = h;
        end
        if (f < 0 && maxp + 1 <= PAGE_MAX) begin
          for (int i = 0; i < NFRAMES; i++)
            if (!tbl_used[i] && f < 0) begin
              f = i;
              tbl_used[i] = 1'b1;
              tbl_owner[i] = c.pid;
              tbl_page[i] = maxp + 1;
              tbl_count[i] = 0;
            end
        end
        if (f < 0) begin
          r.status = ST_NO_FREE;
        end else begin
          tbl_count[f]++;
          r.rframe = FRAME_W'(f);
          r.addr = ADDR_W'(f * l);
        end
      end
      OP_APPEND: begin
        if (!tbl_used[c.frame]) begin
          r.status = ST_NOTFOUND;
        end else if (tbl_count[c.frame] >= l) begin
          r.status = ST_FULL;
        end else begin
          r.rframe = c.frame;
          r.addr = ADDR_W'(c.frame * l + tbl_count[c.frame]);
          tbl_count[c.frame]++;
        end
      end
      OP_XLATE: begin
        tgt = -1;
        line = c.offset;
        if (tbl_used[c.frame]) begin
          tgt = c.frame;
          if (c.offset >= l) begin
            hops = c.offset / l;
            who = tbl_owner[c.frame];
            cur = tbl_page[c.frame];
            line = c.offset % l;
            // each hop moves to the owner's next higher page
            for (int k = 0; k < hops && tgt >= 0; k++) begin
              best = -1;
              for (int i = 0; i < NFRAMES; i++) begin
                p = tbl_page[i];
                if (tbl_used[i] && tbl_owner[i] == who && p > cur && p <= PAGE_LIMIT &&
                    (best < 0 || p < best)) best = p;
              end
              if (best < 0) tgt = -1;
              else cur = best;
            end
            if (tgt >= 0) tgt = lookup_frame(who, cur);
          end
        end
        if (tgt < 0 || line >= tbl_count[tgt]) begin
          r.status = ST_INVALID;
        end else begin
          r.rframe = FRAME_W'(tgt);
          r.addr = ADDR_W'(tgt * l + line);
        end
      end
      default: begin
        f = lookup_frame(c.pid, c.page);
        if (f < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          mv = 0;
          for (int i = f + 1; i < NFRAMES; i++)
            if (tbl_used[i]) mv++;
          // compaction: entries above move down one, last one freed
          for (int d = 0; d < mv; d++) begin
            tbl_used[f+d]  = tbl_used[f+d+1];
            tbl_owner[f+d] = tbl_owner[f+d+1];
            tbl_page[f+d]  = tbl_page[f+d+1];
            tbl_count[f+d] = tbl_count[f+d+1];
          end
          tbl_used[f+mv] = 1'b0;
          tbl_owner[f+mv] = 0;
          tbl_page[f+mv] = 0;
          tbl_count[f+mv] = 0;
          r.rframe = FRAME_W'(f);
          r.moved = FRAME_W'(mv);
        end
      end
    endcase
    for (int i = 0; i < NFRAMES; i++)
      if (tbl_count[i] < l) r.free = r.free + FREE_W'(l - tbl_count[i]);
  endtask

  // sender: bursts with random gaps, predicts on each accepted transaction
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    reply_t r;
    cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        table_update({op, pid, frame, line_offset, page}, r);
        reply_q.push_back(r);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          op <= c.op;
          pid <= c.pid;
          frame <= c.frame;
          line_offset <= c.offset;
          page <= c.page;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(12);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(90);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between free-running, choppy and long holds
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    reply_t e;
    if (!rst && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        $error("result with no expected transaction");
        failed = 1'b1;
      end else begin
        e = reply_q.pop_front();
        if (status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, status);
          failed = 1'b1;
        end
        if (result_frame !== e.rframe) begin
          $error("result_frame: expected %0d, actual %0d", e.rframe, result_frame);
          failed = 1'b1;
        end
        if (line_address !== e.addr) begin
          $error("line_address: expected %0d, actual %0d", e.addr, line_address);
          failed = 1'b1;
        end
        if (moved_frames !== e.moved) begin
          $error("moved_frames: expected %0d, actual %0d", e.moved, moved_frames);
          failed = 1'b1;
        end
        if (free_lines !== e.free) begin
          $error("free_lines: expected %0d, actual %0d", e.free, free_lines);
          failed = 1'b1;
        end
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(2);
      mode_left = $urandom_range(300, 20);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(1);
      default: out_stall <= ($urandom_range(7) != 0);
    endcase
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_cmd(input logic [OP_W-1:0] o, input int p, input int f,
                         input int off, input int pg);
    cmd_t c;
    c.op = o;
    c.pid = OWNER_W'(p);
    c.frame = FRAME_W'(f);
    c.offset = OFFSET_W'(off);
    c.page = PAGE_W'(pg);
    cmd_q.push_back(c);
  endtask

  task automatic lpp_write(input int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * REG_LPP);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    lpp_reg = value & 7'h7f;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || in_valid || reply_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random traffic: few owners and low pages so the table fills and hops happen
  task automatic random_cmds(input int n, input int lpp_val);
    int sel, l, p, off, pg;
    l = (lpp_val < 1) ? 1 : (lpp_val > MAXLPP ? MAXLPP : lpp_val);
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      p = ($urandom_range(4) != 0) ? $urandom_range(3) : $urandom_range(255);
      off = ($urandom_range(49) != 0) ? $urandom_range((4 * l > 2047) ? 2047 : 4 * l)
                                      : $urandom_range(2047);
      pg = ($urandom_range(4) != 0) ? $urandom_range(7) : $urandom_range(16383);
      if (sel < 35) add_cmd(OP_FIRST, p, $urandom_range(31), off, pg);
      else if (sel < 65) add_cmd(OP_APPEND, p, $urandom_range(31), off, pg);
      else if (sel < 88) add_cmd(OP_XLATE, p, $urandom_range(31), off, pg);
      else add_cmd(OP_REMOVE, p, $urandom_range(31), off, pg);
    end
  endtask

  initial begin
    int lpp_set[8] = '{1, 64, 5, 0, 127, 3, 16, 64};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table cases, placement, fill to full, hops
    add_cmd(OP_XLATE, 0, 31, 2047, 0);       // unused frame translate
    add_cmd(OP_APPEND, 0, 0, 0, 0);          // unused frame append
    add_cmd(OP_REMOVE, 255, 0, 0, 16383);    // unknown page
    add_cmd(OP_FIRST, 255, 0, 0, 0);         // first frame, page 0
    add_cmd(OP_FIRST, 255, 0, 0, 0);         // page 0 not empty: page 1
    add_cmd(OP_FIRST, 0, 0, 0, 0);
    for (int i = 0; i < 15; i++) add_cmd(OP_APPEND, 0, 0, 0, 0);
    add_cmd(OP_APPEND, 255, 0, 0, 0);        // frame full
    add_cmd(OP_XLATE, 0, 0, 16, 0);          // hop to the next page
    add_cmd(OP_XLATE, 0, 0, 15, 0);
    add_cmd(OP_XLATE, 0, 0, 17, 0);          // hop, line beyond count
    drain();

    foreach (lpp_set[ph]) begin
      lpp_write(lpp_set[ph]);
      random_cmds(92, lpp_set[ph]);
      drain();
    end

    repeat (200) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/iptlm_pkg.sv
hdl/iptlm_table.sv
hdl/inverted_page_table_line_manager.sv
bench/inverted_page_table_line_manager_tb.sv
